// ===== src/frti_pkg.sv =====
// Shared types and constants for the round-to-integral unit.
package frti_pkg;
	typedef enum logic [2:0] {
		RULE_NEAREST = 3'd0,
		RULE_DOWN    = 3'd1,
		RULE_UP      = 3'd2,
		RULE_ZERO    = 3'd3,
		RULE_AWAY    = 3'd4
	} rule_t;

	localparam logic [2:0] ACT_CURRENT = 3'd0;
	localparam logic [2:0] ACT_FLOOR   = 3'd1;
	localparam logic [2:0] ACT_CEIL    = 3'd2;
	localparam logic [2:0] ACT_TRUNC   = 3'd3;
	localparam logic [2:0] ACT_AWAY    = 3'd4;

	localparam logic [10:0] D_EMAX = 11'h7ff;
	localparam logic [10:0] D_BIAS = 11'h3ff;
	localparam logic [7:0]  S_EMAX = 8'hff;
	localparam logic [7:0]  S_BIAS = 8'h7f;

	typedef struct packed {
		rule_t       rule;
		logic        is_double;
		logic [63:0] operand;
	} req_t;
endpackage

// ===== src/frti_core.sv =====
// Combinational rounding datapath for binary32 and binary64.
module frti_core (
	input  frti_pkg::req_t      req,
	output logic [63:0]         result,
	output logic                inexact
);
	import frti_pkg::*;

	logic        s;
	logic [10:0] e, emax, bias, mbits;
	logic [62:0] mag, mask, half, frac, unit, sum, magmask;
	logic [5:0]  f;
	logic        lsb, inc, special, below_one, abovehalf, athalf;

	always_comb begin
		if (req.is_double) begin
			s     = req.operand[63];
			e     = req.operand[62:52];
			mag   = req.operand[62:0];
			emax  = D_EMAX;
			bias  = D_BIAS;
			mbits = 11'd52;
			magmask = {63{1'b1}};
		end else begin
			s     = req.operand[31];
			e     = {3'd0, req.operand[30:23]};
			mag   = {32'd0, req.operand[30:0]};
			emax  = {3'd0, S_EMAX};
			bias  = {3'd0, S_BIAS};
			mbits = 11'd23;
			magmask = {32'd0, {31{1'b1}}};
		end
		special = (e == emax) || (e >= bias + mbits) || (mag == '0);
		below_one = e < bias;
		f       = 6'((bias + mbits - e));
		unit    = 63'd1 << f;
		mask    = unit - 63'd1;
		half    = unit >> 1;
		frac    = mag & mask;
		lsb     = |(mag & unit);
		abovehalf = (e == bias - 11'd1) && ((mag & ((63'd1 << mbits) - 63'd1)) != '0);
		athalf  = (e == bias - 11'd1);
		inc = 1'b0;
		case (req.rule)
			RULE_DOWN: inc = s;
			RULE_UP:   inc = !s;
			RULE_ZERO: inc = 1'b0;
			RULE_AWAY: inc = below_one ? athalf : (frac >= half);
			default:   inc = below_one ? abovehalf
				: ((frac > half) || (frac == half && lsb));
		endcase
		sum = (mag & ~mask) + (inc ? unit : 63'd0);
		if (special || (!below_one && frac == '0)) begin
			result  = req.is_double ? req.operand : {32'd0, req.operand[31:0]};
			inexact = 1'b0;
		end else if (below_one) begin
			inexact = 1'b1;
			result  = req.is_double ? {s, inc ? {1'b0, D_BIAS[9:0], 52'd0} : 63'd0}
				: {32'd0, s, inc ? {1'b0, S_BIAS[6:0], 23'd0} : 31'd0};
		end else begin
			inexact = 1'b1;
			result  = req.is_double ? {s, sum & magmask} : {32'd0, s, sum[30:0]};
		end
	end
endmodule

// ===== src/float_round_to_integral.sv =====
// Top level of the round-to-integral unit.
// Rounds one IEEE binary32 or binary64 value per request to an integral
// value in the same format, with an inexact flag.
// Input channel: in_valid/in_ready with action, is_double, operand.
// Output channel: out_valid/out_ready with result, inexact.
// Config: cfg_we/cfg_wdata writes rounding_mode (used by action 0 and by actions 5 to 7).
// The accepted request sits in the input register while the rounding logic
// feeds the result register, which drives out_valid, result and inexact.
// Throughput: one request per cycle; each stage advances when the stage
// after it is empty or being drained this cycle.
// Reset clears all valid flags and sets rounding_mode to nearest even.
// When the receiver stalls, the result holds and the stages fill; in_ready
// drops only once both registers hold requests.
module float_round_to_integral (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic        is_double,
	input  logic [63:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result,
	output logic        inexact
);
	import frti_pkg::*;

	logic [1:0]  mode_q;
	logic        v_s1, v_s2;
	req_t        req_s1, req_in;
	logic [63:0] res_c, res_s2;
	logic        inx_c, inx_s2;
	logic        adv2;
	rule_t       rule;

	always_comb begin
		unique case (action)
			ACT_FLOOR: rule = RULE_DOWN;
			ACT_CEIL:  rule = RULE_UP;
			ACT_TRUNC: rule = RULE_ZERO;
			ACT_AWAY:  rule = RULE_AWAY;
			default:   rule = rule_t'({1'b0, mode_q});
		endcase
	end
	assign req_in = '{rule: rule, is_double: is_double, operand: operand};

	assign adv2     = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (in_ready) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) req_s1 <= req_in;
		if (adv2 && v_s1) begin
			res_s2 <= res_c;
			inx_s2 <= inx_c;
		end
	end

	frti_core u_core (.req(req_s1), .result(res_c), .inexact(inx_c));

	assign out_valid = v_s2;
	assign result    = res_s2;
	assign inexact   = inx_s2;
endmodule

// ===== src/frti_checker.sv =====
// Port-level checker for the round-to-integral unit, bound to the top level.
module frti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result,
	input logic        inexact
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(inexact))
		else $error("result changed while stalled");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready |=> ##1 out_valid)
		else $error("accepted request did not appear");
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid in reset");
endmodule

bind float_round_to_integral frti_checker u_frti_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.result(result), .inexact(inexact)
);
